### rtl/core/fat16_cluster_chain_engine_assert.svh
// Assertion macros used by the checker of the cluster chain engine.
`ifndef FAT16_CLUSTER_CHAIN_ENGINE_ASSERT_SVH
`define FAT16_CLUSTER_CHAIN_ENGINE_ASSERT_SVH

// Consequent in the cycle after the antecedent, checking off while in reset.
`define FCCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cluster chain engine check failed");

// Consequent in the same cycle as the antecedent, checking off while in reset.
`define FCCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cluster chain engine check failed");

// Consequent in the cycle after the antecedent, checked through reset as well.
`define FCCE_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("cluster chain engine reset check failed");

`endif

### rtl/core/fcce_pkg.sv
// Shared types, codes and constants of the FAT16 cluster chain engine.
`default_nettype none

package fcce_pkg;

    // Table geometry and field widths.
    localparam int unsigned DEFAULT_TABLE_ENTRIES = 4096;
    localparam int unsigned ENTRY_W   = 16;
    localparam int unsigned CLUSTER_W = 16;
    localparam int unsigned SIZE_W    = 32;
    localparam int unsigned TOTAL_W   = 13;
    localparam int unsigned BPS_W     = 13;
    localparam int unsigned SPC_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 13;
    // Divisor is bytes_per_sector times sectors_per_cluster.
    localparam int unsigned DIV_W     = BPS_W + SPC_W;

    // Table entry codes.
    localparam logic [ENTRY_W-1:0] FIRST_DATA_CLUSTER = 16'h0002;
    localparam logic [ENTRY_W-1:0] FREE_ENTRY         = 16'h0000;
    localparam logic [ENTRY_W-1:0] CHAIN_END_LOW      = 16'hFFF8;
    localparam logic [ENTRY_W-1:0] CHAIN_END          = 16'hFFFF;
    localparam logic [TOTAL_W-1:0] COUNT_MAX          = 13'h1FFF;

    // Register reset values.
    localparam logic [BPS_W-1:0]   BPS_RESET   = 13'd512;
    localparam logic [SPC_W-1:0]   SPC_RESET   = 8'd4;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_SECTOR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_CLUSTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_LIMIT       = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_ALLOC = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_LONG  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ_WAIT,
        S_FREE_CHK,
        S_FREE_RD,
        S_DIV_START,
        S_DIV_RUN,
        S_SCAN,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

### rtl/core/fcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fcce_ram
    import fcce_pkg::*;
#(
    parameter int unsigned WIDTH = ENTRY_W,
    parameter int unsigned DEPTH = DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/fcce_div.sv
// Restoring divider, one quotient bit per cycle, for the cluster count.
`default_nettype none

module fcce_div
    import fcce_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SIZE_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic      [SIZE_W-1:0] o_quotient
);

    localparam int unsigned ITER_W = $clog2(SIZE_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [DIV_W-1:0]  r_rem,  n_rem;
    logic [SIZE_W-1:0] r_quo,  n_quo;
    logic [DIV_W-1:0]  r_dvs,  n_dvs;

    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              fits;

    // One trial subtraction per cycle; the remainder stays below the divisor.
    assign shifted = {r_rem, r_quo[SIZE_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_iter = r_iter;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_iter = ITER_W'(SIZE_W - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            n_quo  = {r_quo[SIZE_W-2:0], fits};
            n_iter = r_iter - ITER_W'(1);
            if (r_iter == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_iter <= n_iter;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dvs  <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### rtl/core/fat16_cluster_chain_engine.sv
// Top level of the FAT16 cluster chain engine: sequencer, table and result register.
//
//  Channel  | Direction | Word contents (low bits first)
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tuser: cmd; tdata: cluster, entry_value, byte size
//  m_axis   | out       | tuser: status; tdata: result_value, cluster_total
//  cfg      | in        | index, data; always ready
//
// After reset a clearing pass zeroes the table, one entry a cycle, before the first
// word is accepted. A write passes S_EXEC and S_RESP, a read also S_READ_WAIT;
// free passes S_FREE_CHK and S_FREE_RD per link walked. Allocate runs the divider,
// then scans one entry a cycle, up to the smaller of cluster limit and table depth.
// A result waiting on m_axis stalls only the next result, not the next accept.
`default_nettype none

module fat16_cluster_chain_engine
    import fcce_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Command words.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [63:0]          s_axis_tdata,  // cluster, entry_value, byte size
    input  wire logic [1:0]           s_axis_tuser,  // cmd
    // Result words.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [31:0]          m_axis_tdata,  // result_value, cluster_total, pad
    output logic      [1:0]           m_axis_tuser,  // status
    // Register writes.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned BW = (CW > TOTAL_W) ? CW : TOTAL_W;
    localparam logic [31:0] NENT = 32'(TABLE_ENTRIES);

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [CW-1:0] v);
        return (32'(v) > 32'(COUNT_MAX)) ? COUNT_MAX : TOTAL_W'(v);
    endfunction

    t_state                r_state, n_state;
    logic [BPS_W-1:0]      r_bps, n_bps;
    logic [SPC_W-1:0]      r_spc, n_spc;
    logic [TOTAL_W-1:0]    r_total, n_total;
    t_cmd                  r_cmd, n_cmd;
    logic [CLUSTER_W-1:0]  r_cluster, n_cluster;
    logic [ENTRY_W-1:0]    r_entry, n_entry;
    logic [SIZE_W-1:0]     r_size, n_size;
    logic [CLUSTER_W-1:0]  r_cur, n_cur;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_want, n_want;
    logic [CW-1:0]         r_scan, n_scan;
    logic                  r_chk_valid, n_chk_valid;
    logic [AW-1:0]         r_chk_addr, n_chk_addr;
    logic [ENTRY_W-1:0]    r_prev, n_prev;
    logic [BW-1:0]         r_end, n_end;
    logic [DIV_W-1:0]      r_divisor, n_divisor;
    t_status               r_res_status, n_res_status;
    logic [ENTRY_W-1:0]    r_res_value, n_res_value;
    logic [TOTAL_W-1:0]    r_res_total, n_res_total;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [ENTRY_W-1:0]    r_out_value, n_out_value;
    logic [TOTAL_W-1:0]    r_out_total, n_out_total;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic                  div_start;
    logic                  div_done;
    logic [SIZE_W-1:0]     div_quotient;

    logic                  in_fire, out_free;
    logic                  cl_range, cur_range, cur_end, count_full;
    logic                  scan_more, hit, last_hit, clear_last, q_long;
    logic [BPS_W-1:0]      bps_eff;
    logic [SPC_W-1:0]      spc_eff;
    logic [DIV_W-1:0]      product;
    logic [BW-1:0]         end_val;
    logic [CW-1:0]         count_inc;

    // Allocation table.
    fcce_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Cluster count divider.
    fcce_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_size),
        .i_divisor  (r_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Conditions shared by the sequencer and the datapath.
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_free   = !r_out_valid || m_axis_tready;
    assign cl_range   = 32'(r_cluster) >= NENT;
    assign cur_range  = 32'(r_cur) >= NENT;
    assign cur_end    = r_cur >= CHAIN_END_LOW;
    assign count_full = 32'(r_count) >= NENT;
    assign scan_more  = BW'(r_scan) < r_end;
    assign hit        = r_chk_valid && (ram_rdata == FREE_ENTRY);
    assign count_inc  = r_count + CW'(1);
    assign last_hit   = hit && (count_inc == r_want);
    assign clear_last = r_scan == CW'(TABLE_ENTRIES - 1);
    assign q_long     = div_quotient >= NENT;

    // A zero divisor counts as one; the two divisions fold into one.
    assign bps_eff = (r_bps == '0) ? BPS_W'(1) : r_bps;
    assign spc_eff = (r_spc == '0) ? SPC_W'(1) : r_spc;
    assign product = DIV_W'(bps_eff) * DIV_W'(spc_eff);

    // Search bound is the smaller of the cluster limit and the table depth.
    assign end_val = (32'(r_total) > NENT) ? BW'(NENT) : BW'(r_total);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_fire) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (r_cmd)
                    CMD_WRITE: n_state = S_RESP;
                    CMD_READ:  n_state = cl_range ? S_RESP : S_READ_WAIT;
                    CMD_FREE:  n_state = S_FREE_CHK;
                    CMD_ALLOC: n_state = S_DIV_START;
                    default:   n_state = S_RESP;
                endcase
            end
            S_READ_WAIT: n_state = S_RESP;
            S_FREE_CHK: begin
                if (cur_end || cur_range || count_full) n_state = S_RESP;
                else n_state = S_FREE_RD;
            end
            S_FREE_RD:   n_state = S_FREE_CHK;
            S_DIV_START: n_state = S_DIV_RUN;
            S_DIV_RUN: begin
                if (div_done) n_state = q_long ? S_RESP : S_SCAN;
            end
            S_SCAN: begin
                if (last_hit || (!hit && !scan_more)) n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Table port, divider start and handshake outputs.
    always_comb begin
        ram_we        = 1'b0;
        ram_waddr     = r_cur[AW-1:0];
        ram_wdata     = FREE_ENTRY;
        ram_raddr     = r_cur[AW-1:0];
        div_start     = 1'b0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_scan[AW-1:0];
            end
            S_IDLE: s_axis_tready = 1'b1;
            S_EXEC: begin
                ram_raddr = r_cluster[AW-1:0];
                if (r_cmd == CMD_WRITE && !cl_range) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cluster[AW-1:0];
                    ram_wdata = r_entry;
                end
            end
            S_FREE_RD:   ram_we = 1'b1;
            S_DIV_START: div_start = 1'b1;
            S_SCAN: begin
                ram_raddr = r_scan[AW-1:0];
                if (hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk_addr;
                    ram_wdata = r_prev;
                end
            end
            default: ;
        endcase
    end

    // Datapath registers and the result word.
    always_comb begin
        n_cmd        = r_cmd;
        n_cluster    = r_cluster;
        n_entry      = r_entry;
        n_size       = r_size;
        n_cur        = r_cur;
        n_count      = r_count;
        n_want       = r_want;
        n_scan       = r_scan;
        n_chk_valid  = r_chk_valid;
        n_chk_addr   = r_chk_addr;
        n_prev       = r_prev;
        n_end        = r_end;
        n_divisor    = r_divisor;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_total  = r_res_total;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_total  = r_out_total;
        unique case (r_state)
            S_CLEAR: n_scan = r_scan + CW'(1);
            S_IDLE: begin
                if (in_fire) begin
                    n_cmd     = t_cmd'(s_axis_tuser);
                    n_cluster = s_axis_tdata[15:0];
                    n_entry   = s_axis_tdata[31:16];
                    n_size    = s_axis_tdata[63:32];
                end
            end
            S_EXEC: begin
                n_res_status = STAT_OK;
                n_res_value  = '0;
                n_res_total  = '0;
                unique case (r_cmd)
                    CMD_WRITE, CMD_READ: begin
                        if (cl_range) n_res_status = STAT_RANGE;
                    end
                    CMD_FREE: begin
                        n_cur   = r_cluster;
                        n_count = '0;
                    end
                    CMD_ALLOC: n_divisor = product;
                    default: ;
                endcase
            end
            S_READ_WAIT: n_res_value = ram_rdata;
            S_FREE_CHK: begin
                n_res_total = sat_total(r_count);
                if (cur_end) n_res_status = STAT_OK;
                else if (cur_range) n_res_status = STAT_RANGE;
                else if (count_full) n_res_status = STAT_LONG;
            end
            S_FREE_RD: begin
                // Entry at r_cur is cleared this cycle; follow its old link.
                n_cur   = ram_rdata;
                n_count = count_inc;
            end
            S_DIV_RUN: begin
                if (div_done) begin
                    if (q_long) begin
                        n_res_status = STAT_LONG;
                    end else begin
                        n_want      = CW'(div_quotient) + CW'(1);
                        n_scan      = CW'(FIRST_DATA_CLUSTER);
                        n_chk_valid = 1'b0;
                        n_count     = '0;
                        n_prev      = CHAIN_END;
                        n_end       = end_val;
                    end
                end
            end
            S_SCAN: begin
                // Reads run one entry ahead of the free check; a taken entry is
                // never free again, so the search goes on from the next one.
                n_chk_valid = scan_more;
                n_chk_addr  = r_scan[AW-1:0];
                if (scan_more) n_scan = r_scan + CW'(1);
                if (hit) begin
                    n_prev  = ENTRY_W'(r_chk_addr);
                    n_count = count_inc;
                end
                if (last_hit) begin
                    n_res_status = STAT_OK;
                    n_res_value  = ENTRY_W'(r_chk_addr);
                    n_res_total  = sat_total(count_inc);
                end else if (!hit && !scan_more) begin
                    n_res_status = STAT_FULL;
                    n_res_value  = '0;
                    n_res_total  = sat_total(r_count);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_out_total  = r_res_total;
                end
            end
            default: ;
        endcase
    end

    // Register writes land at once; the port never stalls.
    always_comb begin
        n_bps   = r_bps;
        n_spc   = r_spc;
        n_total = r_total;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BYTES_PER_SECTOR:    n_bps   = i_cfg_data[BPS_W-1:0];
                CFG_SECTORS_PER_CLUSTER: n_spc   = i_cfg_data[SPC_W-1:0];
                CFG_CLUSTER_LIMIT:       n_total = i_cfg_data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_scan      <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_bps       <= BPS_RESET;
            r_spc       <= SPC_RESET;
            r_total     <= TOTAL_RESET;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
            r_bps       <= n_bps;
            r_spc       <= n_spc;
            r_total     <= n_total;
        end
        r_cmd        <= n_cmd;
        r_cluster    <= n_cluster;
        r_entry      <= n_entry;
        r_size       <= n_size;
        r_cur        <= n_cur;
        r_count      <= n_count;
        r_want       <= n_want;
        r_chk_addr   <= n_chk_addr;
        r_prev       <= n_prev;
        r_end        <= n_end;
        r_divisor    <= n_divisor;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_total  <= n_res_total;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_total  <= n_out_total;
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_total, r_out_value};
    assign m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

### rtl/core/fcce_checker.sv
// Port-level checker of the cluster chain engine and its bind to the top level.
`include "fat16_cluster_chain_engine_assert.svh"
`default_nettype none

module fcce_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // A stalled result word stays offered and unchanged.
    `FCCE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `FCCE_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Once a command word is taken the engine is busy with it.
    `FCCE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Reset starts the clearing pass and drops any pending result.
    `FCCE_ASSERT_RST(a_reset_quiet, !i_rst_n, !s_axis_tready && !m_axis_tvalid)

endmodule

bind fat16_cluster_chain_engine fcce_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
